>>> rtl/core/vmvs_pkg.sv
// Shared widths, limits and word types of the vector mean and variance block.
`default_nettype none
package vmvs_pkg;

	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned SUM_W       = 28;
	localparam int unsigned SQSUM_W     = 43;
	localparam int unsigned SQ_W        = 31;
	localparam int unsigned CNT_W       = 13;
	localparam int unsigned AVG_W       = 16;
	localparam int unsigned VAR_W       = 31;
	localparam int unsigned DEV_W       = 16;
	localparam int unsigned MAX_COUNT   = 4096;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Input word: one sample, last one of a vector marked
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} in_t;

	// Output word: statistics of one vector
	typedef struct packed {
		logic signed [SUM_W-1:0] total;
		logic signed [AVG_W-1:0] average;
		logic [VAR_W-1:0]        variance;
		logic [DEV_W-1:0]        deviation;
		logic [CNT_W-1:0]        sample_count;
		logic                    overflow;
	} out_t;

	// Finished accumulation of one vector, handed from front to back
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SQSUM_W-1:0]      sqsum;
		logic [CNT_W-1:0]        count;
		logic                    dropped;
	} run_t;

endpackage
`default_nettype wire

>>> rtl/core/vector_mean_variance_stats.sv
// Top level: sum, mean, variance and deviation of vectors of signed samples.
// Throughput: one sample word per cycle unless the input stalls on a full queue; each
//   vector then passes the back end (load, two 43-step divides on one shared divider,
//   square, subtract, a 16-step square root and output), decoupled by a two-entry queue.
// The result word of a vector is registered by the back end after it leaves the queue.
// Reset clears accumulators, queue and sequencer; no result is pending after it.
`default_nettype none
module vector_mean_variance_stats (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  wire vmvs_pkg::in_t  item,
	output logic                result_valid,
	input  wire logic           result_stall,
	output vmvs_pkg::out_t      result
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	vmvs_pkg::run_t q_wdata;
	vmvs_pkg::run_t q_rdata;

	vmvs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (q_push),
		.rec        (q_wdata),
		.full       (q_full)
	);

	vmvs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	vmvs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (q_pop),
		.empty        (q_empty),
		.rec          (q_rdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Never push a vector into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("vector pushed into full queue");

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("pop from empty queue");

	// Input stalls only for lack of queue room
	assert property (@(posedge clk) disable iff (!arst_n) item_stall |-> q_full)
		else $error("input stalled with queue room");

endmodule
`default_nettype wire

>>> rtl/core/vmvs_front.sv
// Front end: accepts samples, squares them and accumulates one vector at a time.
`default_nettype none
module vmvs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire vmvs_pkg::in_t item,
	output logic               push,
	output vmvs_pkg::run_t     rec,
	input  wire logic          full
);

	logic                                  v_s1;
	logic signed [vmvs_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                                  last_s1;
	logic [vmvs_pkg::SQ_W-1:0]             sq_s1;
	logic signed [2*vmvs_pkg::SAMPLE_W-1:0] sq_full;

	logic signed [vmvs_pkg::SUM_W-1:0] sum_q;
	logic [vmvs_pkg::SQSUM_W-1:0]      sqsum_q;
	logic [vmvs_pkg::CNT_W-1:0]        count_q;
	logic                              dropped_q;

	logic                              hold;
	logic                              take;
	logic                              room;
	logic signed [vmvs_pkg::SUM_W-1:0] sum_n;
	logic [vmvs_pkg::SQSUM_W-1:0]      sqsum_n;
	logic [vmvs_pkg::CNT_W-1:0]        count_n;

	// Hold the closing word while the queue has no room for its vector
	assign hold       = v_s1 && last_s1 && full;
	assign item_stall = hold;
	assign take       = v_s1 && !hold;
	assign sq_full    = item.sample * item.sample;

	// Stage 1: register the word and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			sample_s1 <= '0;
			last_s1   <= 1'b0;
			sq_s1     <= '0;
		end else if (!hold) begin
			v_s1 <= item_valid;
			if (item_valid) begin
				sample_s1 <= item.sample;
				last_s1   <= item.last;
				sq_s1     <= sq_full[vmvs_pkg::SQ_W-1:0];
			end
		end
	end

	// Next accumulator values; a full vector drops further samples
	always_comb begin
		room    = count_q < vmvs_pkg::CNT_W'(vmvs_pkg::MAX_COUNT);
		sum_n   = sum_q + {{(vmvs_pkg::SUM_W-vmvs_pkg::SAMPLE_W){sample_s1[vmvs_pkg::SAMPLE_W-1]}},
			sample_s1};
		sqsum_n = sqsum_q + {{(vmvs_pkg::SQSUM_W-vmvs_pkg::SQ_W){1'b0}}, sq_s1};
		count_n = count_q + 1'b1;
		rec.sum     = room ? sum_n : sum_q;
		rec.sqsum   = room ? sqsum_n : sqsum_q;
		rec.count   = room ? count_n : count_q;
		rec.dropped = dropped_q | !room;
		push        = take && last_s1;
	end

	// Stage 2: accumulate, clear after the last word of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			sqsum_q   <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (take) begin
			if (last_s1) begin
				sum_q     <= '0;
				sqsum_q   <= '0;
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (room) begin
				sum_q   <= sum_n;
				sqsum_q <= sqsum_n;
				count_q <= count_n;
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vmvs_queue.sv
// Short queue of finished vector accumulations between front and back end.
`default_nettype none
module vmvs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire vmvs_pkg::run_t wdata,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output vmvs_pkg::run_t      rdata
);

	localparam int unsigned PTR_W = (vmvs_pkg::QUEUE_DEPTH > 1) ?
		$clog2(vmvs_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(vmvs_pkg::QUEUE_DEPTH + 1);

	vmvs_pkg::run_t      mem_q [vmvs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [FILL_W-1:0]   fill_q;

	assign full  = fill_q == FILL_W'(vmvs_pkg::QUEUE_DEPTH);
	assign empty = fill_q == '0;
	assign rdata = mem_q[rd_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(vmvs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(vmvs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vmvs_back.sv
// Back end: divides, squares and takes the square root for each finished vector.
`default_nettype none
module vmvs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	output logic                pop,
	input  wire logic           empty,
	input  wire vmvs_pkg::run_t rec,
	output logic                result_valid,
	input  wire logic           result_stall,
	output vmvs_pkg::out_t      result
);

	localparam int unsigned STEP_W = $clog2(vmvs_pkg::SQSUM_W);
	localparam int unsigned MAG_W  = vmvs_pkg::AVG_W + 1;
	localparam int unsigned RAD_W  = 2 * vmvs_pkg::DEV_W;
	localparam int unsigned SREM_W = vmvs_pkg::DEV_W + 4;

	typedef enum logic [2:0] {
		IDLE,
		DIV_SQ,
		DIV_SUM,
		SQUARE,
		DIFF,
		ROOT,
		DONE
	} state_t;

	state_t                            state_q;
	logic [STEP_W-1:0]                 step_q;
	logic [vmvs_pkg::SQSUM_W-1:0]      dvd_q;
	logic [vmvs_pkg::CNT_W-1:0]        rem_q;
	logic [vmvs_pkg::CNT_W-1:0]        cnt_q;
	logic signed [vmvs_pkg::SUM_W-1:0] sum_q;
	logic                              dropped_q;
	logic [vmvs_pkg::SQ_W-1:0]         msq_q;
	logic [MAG_W-1:0]                  mag_q;
	logic [vmvs_pkg::SQ_W-1:0]         sq_q;
	logic [vmvs_pkg::VAR_W-1:0]        var_q;
	logic [RAD_W-1:0]                  rad_q;
	logic [SREM_W-1:0]                 srem_q;
	logic [vmvs_pkg::DEV_W-1:0]        root_q;
	logic                              result_valid_q;
	vmvs_pkg::out_t                    result_q;

	logic [vmvs_pkg::CNT_W:0]          rem_sh;
	logic [vmvs_pkg::CNT_W:0]          rem_dif;
	logic                              qbit;
	logic [vmvs_pkg::CNT_W-1:0]        rem_n;
	logic [vmvs_pkg::SUM_W-1:0]        sum_mag;
	logic [2*MAG_W-1:0]                sq_full;
	logic [vmvs_pkg::SQ_W:0]           diff;
	logic [SREM_W-1:0]                 srem_sh;
	logic [SREM_W-1:0]                 trial;
	logic                              rbit;
	logic [MAG_W-1:0]                  avg_s;
	logic                              zero_cnt;

	assign pop          = (state_q == IDLE) && !empty;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// One restoring divide step, one square-root digit step, and helpers
	always_comb begin
		rem_sh  = {rem_q, dvd_q[vmvs_pkg::SQSUM_W-1]};
		rem_dif = rem_sh - {1'b0, cnt_q};
		qbit    = rem_sh >= {1'b0, cnt_q};
		rem_n   = qbit ? rem_dif[vmvs_pkg::CNT_W-1:0] : rem_sh[vmvs_pkg::CNT_W-1:0];
		sum_mag = sum_q[vmvs_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
		sq_full = mag_q * mag_q;
		diff    = {1'b0, msq_q} - {1'b0, sq_q};
		srem_sh = {srem_q[SREM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial   = {2'b00, root_q, 2'b01};
		rbit    = srem_sh >= trial;
		avg_s   = sum_q[vmvs_pkg::SUM_W-1] ? (~mag_q + 1'b1) : mag_q;
		zero_cnt = cnt_q == '0;
	end

	// Sequencer: take a vector, divide twice, square, subtract, root, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			step_q         <= '0;
			dvd_q          <= '0;
			rem_q          <= '0;
			cnt_q          <= '0;
			sum_q          <= '0;
			dropped_q      <= 1'b0;
			msq_q          <= '0;
			mag_q          <= '0;
			sq_q           <= '0;
			var_q          <= '0;
			rad_q          <= '0;
			srem_q         <= '0;
			root_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// Raise the result word when the back end finishes, drop it once taken
			if (state_q == DONE && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (!empty) begin
						cnt_q     <= rec.count;
						sum_q     <= rec.sum;
						dropped_q <= rec.dropped;
						dvd_q     <= rec.sqsum;
						rem_q     <= '0;
						step_q    <= '0;
						state_q   <= DIV_SQ;
					end
				end
				DIV_SQ: begin
					if (step_q == STEP_W'(vmvs_pkg::SQSUM_W - 1)) begin
						msq_q   <= {dvd_q[vmvs_pkg::SQ_W-2:0], qbit};
						dvd_q   <= {{(vmvs_pkg::SQSUM_W-vmvs_pkg::SUM_W){1'b0}}, sum_mag};
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= DIV_SUM;
					end else begin
						dvd_q  <= {dvd_q[vmvs_pkg::SQSUM_W-2:0], qbit};
						rem_q  <= rem_n;
						step_q <= step_q + 1'b1;
					end
				end
				DIV_SUM: begin
					dvd_q  <= {dvd_q[vmvs_pkg::SQSUM_W-2:0], qbit};
					rem_q  <= rem_n;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(vmvs_pkg::SQSUM_W - 1)) begin
						mag_q   <= {dvd_q[MAG_W-2:0], qbit};
						state_q <= SQUARE;
					end
				end
				SQUARE: begin
					sq_q    <= sq_full[vmvs_pkg::SQ_W-1:0];
					state_q <= DIFF;
				end
				DIFF: begin
					// Clamp a negative difference to zero
					var_q   <= diff[vmvs_pkg::SQ_W] ? '0 : diff[vmvs_pkg::VAR_W-1:0];
					rad_q   <= diff[vmvs_pkg::SQ_W] ? '0 :
						{{(RAD_W-vmvs_pkg::VAR_W){1'b0}}, diff[vmvs_pkg::VAR_W-1:0]};
					srem_q  <= '0;
					root_q  <= '0;
					step_q  <= '0;
					state_q <= ROOT;
				end
				ROOT: begin
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					srem_q <= rbit ? (srem_sh - trial) : srem_sh;
					root_q <= {root_q[vmvs_pkg::DEV_W-2:0], rbit};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(vmvs_pkg::DEV_W - 1)) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q.total        <= zero_cnt ? '0 : sum_q;
						result_q.average      <= zero_cnt ? '0 : avg_s[vmvs_pkg::AVG_W-1:0];
						result_q.variance     <= zero_cnt ? '0 : var_q;
						result_q.deviation    <= zero_cnt ? '0 : root_q;
						result_q.sample_count <= cnt_q;
						result_q.overflow     <= dropped_q;
						state_q               <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
